[rtl/alignment_overlap_suppression_macros.svh]
// assertion macros used by the rtl top level
`ifndef ALIGNMENT_OVERLAP_SUPPRESSION_MACROS_SVH
`define ALIGNMENT_OVERLAP_SUPPRESSION_MACROS_SVH
`define AOS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AOS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/aos_pkg.sv]
package aos_pkg;
	localparam int MaxRecords = 64;
	localparam int CoordBits  = 32;
	localparam int PosBits    = 6;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT,
		ST_SUPP,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	// one record as held in a cell
	typedef struct packed {
		logic                  live;
		logic                  keep;
		logic [PosBits-1:0]    pos;
		logic [31:0]           rd;
		logic signed [31:0]    score;
		logic [CoordBits-1:0]  first;
		logic [CoordBits-1:0]  final_q;
	} rec_t;

	// commands from the controller to the cells
	typedef struct packed {
		logic load;
		logic sort_even;
		logic sort_odd;
		logic supp;
		logic shift;
		logic clear;
	} cell_ctl_t;

	// true if a must be placed before b
	function automatic logic ranks_before(rec_t a, rec_t b);
		if (a.rd != b.rd)
			return a.rd < b.rd;
		return a.score > b.score;
	endfunction

	// b is suppressed by a
	function automatic logic overlaps(rec_t a, rec_t b);
		logic [CoordBits-1:0] s;
		logic [CoordBits-1:0] e;
		logic [CoordBits:0]   ov2;
		logic [CoordBits-1:0] len;
		s = (a.first > b.first) ? a.first : b.first;
		e = (a.final_q < b.final_q) ? a.final_q : b.final_q;
		len = b.final_q - b.first;
		ov2 = (e > s) ? {e - s, 1'b0} : '0;
		return (b.final_q >= b.first) && (ov2 > {1'b0, len});
	endfunction
endpackage

[rtl/aos_cell.sv]
// one cell: holds a record, takes part in load, odd-even sort, suppression, shift and clear
module aos_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  aos_pkg::cell_ctl_t ctl,
	input  logic              load_here,
	input  aos_pkg::rec_t     load_rec,
	input  aos_pkg::rec_t     prev_rec,
	input  aos_pkg::rec_t     next_rec,
	input  logic              even_pos,
	input  aos_pkg::rec_t     head_rec,
	output aos_pkg::rec_t     rec
);
	aos_pkg::rec_t rec_q;
	aos_pkg::rec_t nxt;
	logic          low_side;
	logic          swap_lo;
	logic          swap_hi;

	assign rec = rec_q;

	always_comb begin
		nxt      = rec_q;
		low_side = (ctl.sort_even && even_pos) || (ctl.sort_odd && !even_pos);
		// pair with next when low side, with prev otherwise
		swap_lo  = next_rec.live && rec_q.live && aos_pkg::ranks_before(next_rec, rec_q);
		swap_hi  = rec_q.live && prev_rec.live && aos_pkg::ranks_before(rec_q, prev_rec);
		priority if (ctl.load) begin
			if (load_here)
				nxt = load_rec;
		end else if (ctl.sort_even || ctl.sort_odd) begin
			if (low_side && swap_lo)
				nxt = next_rec;
			else if (!low_side && swap_hi)
				nxt = prev_rec;
		end else if (ctl.supp) begin
			// shift towards the head, dropping keep of records the head covers
			nxt = next_rec;
			if (head_rec.keep && next_rec.live && next_rec.keep && next_rec.rd == head_rec.rd
					&& aos_pkg::overlaps(head_rec, next_rec))
				nxt.keep = 1'b0;
		end else if (ctl.shift) begin
			nxt = next_rec;
		end else if (ctl.clear) begin
			nxt.live = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else begin
			rec_q <= nxt;
		end
	end
endmodule

[rtl/aos_ctrl.sv]
// batch sequencer: load, sort passes, suppression walk, emission, or an empty-batch result
module aos_ctrl #(
	parameter int MAX_RECORDS = aos_pkg::MaxRecords
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_xfer,
	input  logic               in_end,
	input  logic               head_live,
	input  logic               head_keep,
	input  logic               any_kept,
	input  logic               out_free,
	output aos_pkg::cell_ctl_t ctl,
	output logic               in_ready,
	output logic [$clog2(MAX_RECORDS+1)-1:0] count,
	output aos_pkg::state_t    state,
	output logic               ovf
);
	localparam int CntW = $clog2(MAX_RECORDS + 1);
	aos_pkg::state_t state_q;
	aos_pkg::state_t state_nxt;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] step_q;
	logic            ovf_q;
	logic            full;

	assign full  = count_q == CntW'(MAX_RECORDS);
	assign count = count_q;
	assign state = state_q;
	assign ovf   = ovf_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			aos_pkg::ST_LOAD:
				if (in_xfer && in_end)
					state_nxt = aos_pkg::ST_SORT;
			aos_pkg::ST_SORT:
				if (step_q == count_q)
					state_nxt = any_kept ? aos_pkg::ST_SUPP : aos_pkg::ST_EMPTY;
			aos_pkg::ST_SUPP:
				if (!head_live)
					state_nxt = aos_pkg::ST_EMIT;
			aos_pkg::ST_EMIT:
				if (!head_live)
					state_nxt = aos_pkg::ST_LOAD;
			aos_pkg::ST_EMPTY:
				if (out_free)
					state_nxt = aos_pkg::ST_LOAD;
			default:
				state_nxt = aos_pkg::ST_LOAD;
		endcase
	end

	// suppression shifts the chain: head compares, then leaves; only a kept head enters the emit queue
	always_comb begin
		ctl       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			aos_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				ctl.load = in_xfer && !full;
			end
			aos_pkg::ST_SORT: begin
				ctl.sort_even = (step_q != count_q) && !step_q[0];
				ctl.sort_odd  = (step_q != count_q) && step_q[0];
			end
			aos_pkg::ST_SUPP: begin
				ctl.supp = head_live;
			end
			aos_pkg::ST_EMIT: begin
				ctl.shift = head_live && (out_free || !head_keep);
			end
			aos_pkg::ST_EMPTY: begin
				ctl.clear = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aos_pkg::ST_LOAD;
			count_q <= '0;
			step_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load)
				count_q <= count_q + 1'b1;
			if (state_q == aos_pkg::ST_LOAD && in_xfer && full)
				ovf_q <= 1'b1;
			if (state_q == aos_pkg::ST_SORT && step_q != count_q)
				step_q <= step_q + 1'b1;
			if ((state_q == aos_pkg::ST_EMIT && !head_live) || ctl.clear) begin
				count_q <= '0;
				step_q  <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end
endmodule

[rtl/alignment_overlap_suppression.sv]
// Alignment overlap suppression over a chain of record cells. Records
// load one per cycle into successive cells; the item carrying batch_end
// starts processing, and the input stays stalled until the whole batch
// has been emitted. An odd-even transposition sort orders the held
// records, then the suppression walk shifts the chain past its head, one
// record per cycle, queueing the kept ones. Emission reads that queue,
// one result per cycle while the output is free. Records beyond
// MAX_RECORDS are dropped and reported through overflowed.
`include "alignment_overlap_suppression_macros.svh"
module alignment_overlap_suppression #(
	parameter int MAX_RECORDS = aos_pkg::MaxRecords,
	parameter int COORD_BITS  = aos_pkg::CoordBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [31:0]         read_index,
	input  logic signed [31:0]  align_score,
	input  logic [31:0]         query_first,
	input  logic [31:0]         query_final,
	input  logic                keep_initially,
	input  logic                batch_end,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                valid_res,
	output logic [5:0]          load_position,
	output logic [31:0]         out_read,
	output logic signed [31:0]  out_score,
	output logic [31:0]         out_first,
	output logic [31:0]         out_final,
	output logic                overflowed,
	output logic                last
);
	localparam int CntW = $clog2(MAX_RECORDS + 1);
	localparam int IdxW = $clog2(MAX_RECORDS);
	localparam logic [31:0] CMask = (COORD_BITS >= 32) ? 32'hFFFF_FFFF
		: ((32'd1 << COORD_BITS) - 32'd1);

	aos_pkg::cell_ctl_t ctl;
	aos_pkg::state_t    state;
	aos_pkg::rec_t      recs [MAX_RECORDS];
	aos_pkg::rec_t      load_rec;
	aos_pkg::rec_t      blank;
	logic [CntW-1:0]    count;
	logic               in_ready;
	logic               ovf;
	logic               in_xfer;
	logic               out_free;
	logic               any_kept;
	logic [MAX_RECORDS-1:0] kept_vec;

	assign in_stall = !in_ready;
	assign in_xfer  = in_valid && in_ready;

	always_comb begin
		blank = '0;
		load_rec.live    = 1'b1;
		load_rec.keep    = keep_initially;
		load_rec.pos     = aos_pkg::PosBits'(count);
		load_rec.rd      = read_index;
		load_rec.score   = align_score;
		load_rec.first   = query_first & CMask;
		load_rec.final_q = query_final & CMask;
	end

	// shifts move towards the head, blank enters at the tail
	genvar g;
	generate
		for (g = 0; g < MAX_RECORDS; g++) begin : g_cell
			aos_pkg::rec_t nb;
			aos_pkg::rec_t pv;
			assign kept_vec[g] = recs[g].live && recs[g].keep;
			if (g == MAX_RECORDS - 1) begin : g_tail
				assign nb = blank;
			end else begin : g_mid
				assign nb = recs[g+1];
			end
			if (g == 0) begin : g_head
				assign pv = blank;
			end else begin : g_body
				assign pv = recs[g-1];
			end
			aos_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.load_here(count == CntW'(g)),
				.load_rec (load_rec),
				.prev_rec (pv),
				.next_rec (nb),
				.even_pos (g % 2 == 0),
				.head_rec (recs[0]),
				.rec      (recs[g])
			);
		end
	endgenerate

	assign any_kept = |kept_vec;

	// suppression copies each kept head to the emit queue
	aos_pkg::rec_t      q_mem [MAX_RECORDS];
	logic [CntW-1:0]    q_wr_q;
	logic [CntW-1:0]    q_rd_q;
	logic               o_valid_q;
	logic               o_last_q;
	aos_pkg::rec_t      o_rec_q;
	logic               o_ovf_q;
	logic               emitting;

	assign out_free = !o_valid_q || !out_stall;
	assign emitting = state == aos_pkg::ST_EMIT;

	always_ff @(posedge clk) begin
		if (ctl.supp && recs[0].keep)
			q_mem[q_wr_q[IdxW-1:0]] <= recs[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q    <= '0;
			q_rd_q    <= '0;
			o_valid_q <= 1'b0;
		end else begin
			if (ctl.supp && recs[0].keep)
				q_wr_q <= q_wr_q + 1'b1;
			else if (emitting && q_rd_q == q_wr_q)
				q_wr_q <= '0;
			if (emitting && q_rd_q == q_wr_q)
				q_rd_q <= '0;
			else if (emitting && out_free)
				q_rd_q <= q_rd_q + 1'b1;
			if ((emitting && out_free && q_rd_q != q_wr_q) || ctl.clear)
				o_valid_q <= 1'b1;
			else if (out_free)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emitting && out_free && q_rd_q != q_wr_q) begin
			o_rec_q  <= q_mem[q_rd_q[IdxW-1:0]];
			o_last_q <= (q_rd_q + 1'b1) == q_wr_q;
			o_ovf_q  <= ovf;
		end
		if (ctl.clear) begin
			o_rec_q  <= blank;
			o_last_q <= 1'b1;
			o_ovf_q  <= ovf;
		end
	end

	aos_ctrl #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_xfer  (in_xfer),
		.in_end   (batch_end),
		.head_live(state == aos_pkg::ST_SUPP ? recs[0].live : (q_rd_q != q_wr_q)),
		.head_keep(1'b1),
		.any_kept (any_kept),
		.out_free (out_free),
		.ctl      (ctl),
		.in_ready (in_ready),
		.count    (count),
		.state    (state),
		.ovf      (ovf)
	);

	assign out_valid     = o_valid_q;
	assign valid_res     = o_rec_q.live;
	assign load_position = o_rec_q.pos;
	assign out_read      = o_rec_q.rd;
	assign out_score     = o_rec_q.score;
	assign out_first     = o_rec_q.first;
	assign out_final     = o_rec_q.final_q;
	assign overflowed    = o_ovf_q;
	assign last          = o_last_q;

	`AOS_ASSERT(a_no_load_busy, (state != aos_pkg::ST_LOAD) |-> in_stall, "input taken while busy")
	`AOS_ASSERT(a_count_cap, count <= CntW'(MAX_RECORDS), "record count beyond capacity")
	`AOS_ASSERT(a_queue_order, q_rd_q <= q_wr_q, "emit queue read passed write")
	`AOS_ASSERT(a_hold, (out_valid && out_stall) |=> $stable(out_read), "result changed while stalled")
endmodule

[dv/tb_alignment_overlap_suppression.sv]
module tb_alignment_overlap_suppression;

	localparam int Cap = aos_pkg::MaxRecords;

	typedef struct packed {
		logic        valid_res;
		logic [5:0]  pos;
		logic [31:0] rd;
		logic [31:0] score;
		logic [31:0] first;
		logic [31:0] final_q;
		logic        ovf;
		logic        last;
	} kept_t;

	typedef struct packed {
		logic [31:0] rd;
		logic [31:0] score;
		logic [31:0] first;
		logic [31:0] final_q;
		logic        keep;
		logic        bend;
	} rec_in_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] read_index = '0;
	logic signed [31:0] align_score = '0;
	logic [31:0] query_first = '0;
	logic [31:0] query_final = '0;
	logic keep_initially = 1'b0;
	logic batch_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic valid_res;
	logic [5:0] load_position;
	logic [31:0] out_read;
	logic signed [31:0] out_score;
	logic [31:0] out_first;
	logic [31:0] out_final;
	logic overflowed;
	logic last;

	alignment_overlap_suppression i_dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] b_rd [Cap];
	logic signed [31:0] b_score [Cap];
	logic [31:0] b_first [Cap];
	logic [31:0] b_final [Cap];
	logic b_keep [Cap];
	int b_count = 0;
	logic b_ovf = 1'b0;

	kept_t kept_q[$];
	int errors = 0;
	int n_results = 0;
	int n_batches = 0;
	int n_sent = 0;
	bit calm = 0;
	bit hold_long = 0;

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	function automatic bit ahead(int a, int b);
		if (b_rd[a] != b_rd[b])
			return b_rd[a] < b_rd[b];
		return b_score[a] > b_score[b];
	endfunction

	function automatic void predict_record(rec_in_t r);
		int ord [Cap];
		int cur, j, a, b, n, emitted;
		logic [32:0] s, e, ov, len;
		kept_t k;
		if (b_count < Cap) begin
			b_rd[b_count] = r.rd;
			b_score[b_count] = r.score;
			b_first[b_count] = r.first;
			b_final[b_count] = r.final_q;
			b_keep[b_count] = r.keep;
			b_count++;
		end else
			b_ovf = 1'b1;
		if (!r.bend)
			return;
		n = b_count;
		for (int i = 0; i < n; i++)
			ord[i] = i;
		for (int i = 1; i < n; i++) begin
			cur = ord[i];
			j = i;
			while (j > 0 && ahead(cur, ord[j-1])) begin
				ord[j] = ord[j-1];
				j--;
			end
			ord[j] = cur;
		end
		for (int i = 0; i < n; i++) begin
			a = ord[i];
			if (!b_keep[a])
				continue;
			for (int m = i + 1; m < n; m++) begin
				b = ord[m];
				if (!b_keep[b])
					continue;
				if (b_rd[b] != b_rd[a])
					break;
				if (b_final[b] < b_first[b])
					continue;
				s = (b_first[a] > b_first[b]) ? b_first[a] : b_first[b];
				e = (b_final[a] < b_final[b]) ? b_final[a] : b_final[b];
				ov = (e > s) ? e - s : '0;
				len = b_final[b] - b_first[b];
				if ((ov << 1) > len)
					b_keep[b] = 1'b0;
			end
		end
		emitted = 0;
		for (int i = 0; i < n; i++) begin
			a = ord[i];
			if (!b_keep[a])
				continue;
			k = '{1'b1, a[5:0], b_rd[a], b_score[a], b_first[a], b_final[a], b_ovf, 1'b0};
			kept_q.push_back(k);
			emitted++;
		end
		if (emitted == 0)
			kept_q.push_back('{1'b0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, b_ovf, 1'b1});
		else
			kept_q[$].last = 1'b1;
		b_count = 0;
		b_ovf = 1'b0;
	endfunction

	// result checking
	always @(posedge clk) begin
		kept_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (kept_q.size() == 0) begin
				report("unexpected result", out_read, 32'd0);
			end else begin
				w = kept_q.pop_front();
				if (valid_res !== w.valid_res) report("valid_res", valid_res, w.valid_res);
				if (load_position !== w.pos) report("load_position", load_position, w.pos);
				if (out_read !== w.rd) report("out_read", out_read, w.rd);
				if (out_score !== w.score) report("out_score", out_score, w.score);
				if (out_first !== w.first) report("out_first", out_first, w.first);
				if (out_final !== w.final_q) report("out_final", out_final, w.final_q);
				if (overflowed !== w.ovf) report("overflowed", overflowed, w.ovf);
				if (last !== w.last) report("last", last, w.last);
				if (w.last) n_batches++;
			end
		end
	end

	// receiver stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (1000) @(posedge clk);
				hold_long = 0;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (gap - 1) @(posedge clk);
				@(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send(input rec_in_t r);
		if (!calm && $urandom_range(0, 6) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		read_index <= r.rd;
		align_score <= r.score;
		query_first <= r.first;
		query_final <= r.final_q;
		keep_initially <= r.keep;
		batch_end <= r.bend;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_record(r);
		n_sent++;
	endtask

	task automatic idle_wait;
		in_valid <= 1'b0;
		@(posedge clk);
		while (kept_q.size() != 0) @(posedge clk);
	endtask

	function automatic rec_in_t rand_rec(int reads, bit bend, bit wide);
		rec_in_t r;
		logic [31:0] f;
		r.rd = wide ? $urandom : $urandom_range(0, reads - 1);
		r.score = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40) - 20;
		f = wide ? $urandom : $urandom_range(0, 200);
		r.first = f;
		r.final_q = ($urandom_range(0, 9) == 0) ? f - $urandom_range(0, 30)
			: (wide ? $urandom : f + $urandom_range(0, 100));
		r.keep = ($urandom_range(0, 4) != 0);
		r.bend = bend;
		return r;
	endfunction

	// directed rows with expected single result where obvious
	rec_in_t dir_rows [] = '{
		'{32'd5, 32'd10, 32'd0, 32'd100, 1'b1, 1'b1},
		'{32'hffffffff, 32'h80000000, 32'hffffffff, 32'hffffffff, 1'b1, 1'b1},
		'{32'd0, 32'h7fffffff, 32'd0, 32'd0, 1'b0, 1'b1},
		'{32'd1, 32'd5, 32'd0, 32'd100, 1'b1, 1'b0},
		'{32'd1, 32'd9, 32'd10, 32'd90, 1'b1, 1'b0},
		'{32'd1, 32'd3, 32'd80, 32'd200, 1'b1, 1'b0},
		'{32'd1, 32'd7, 32'd50, 32'd20, 1'b1, 1'b0},
		'{32'd0, 32'd1, 32'd0, 32'd100, 1'b1, 1'b0},
		'{32'd1, 32'd9, 32'd10, 32'd90, 1'b1, 1'b0},
		'{32'd1, 32'd2, 32'd0, 32'd20, 1'b1, 1'b0},
		'{32'd1, 32'd2, 32'd0, 32'd21, 1'b1, 1'b1},
		'{32'd2, 32'd1, 32'd0, 32'hffffffff, 1'b1, 1'b0},
		'{32'd2, 32'h80000000, 32'h0, 32'hffffffff, 1'b1, 1'b1}
	};
	kept_t dir_want [3] = '{
		'{1'b1, 6'd0, 32'd5, 32'd10, 32'd0, 32'd100, 1'b0, 1'b1},
		'{1'b1, 6'd0, 32'hffffffff, 32'h80000000, 32'hffffffff, 32'hffffffff, 1'b0, 1'b1},
		'{1'b0, 6'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}
	};

	initial begin
		int size, target;
		rec_in_t r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send(dir_rows[i]);
			if (i < 3 && kept_q.size() == 1 && kept_q[0] !== dir_want[i])
				report($sformatf("directed row %0d", i), kept_q[0].rd, dir_want[i].rd);
			if (dir_rows[i].bend) idle_wait();
		end
		// capacity: fill past the limit, receiver held off while the sender keeps offering
		hold_long = 1;
		for (int i = 0; i < Cap + 3; i++)
			send(rand_rec(4, i == Cap + 2, i % 2));
		// random batches, mostly small
		target = n_sent + 80;
		while (n_sent < target) begin
			if (target - n_sent < 30) calm = 1;
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
			for (int i = 0; i < size; i++) begin
				r = rand_rec($urandom_range(1, 4), i == size - 1, $urandom_range(0, 7) == 0);
				send(r);
			end
			if ($urandom_range(0, 2) == 0) idle_wait();
		end
		idle_wait();
		repeat (300) @(posedge clk);
		$display("sent %0d records in %0d batches, checked %0d results", n_sent, n_batches,
			n_results);
		$display("covered overflow, empty batches, reversed spans and a long output hold-off");
		if (errors == 0 && kept_q.size() == 0)
			$display("** alignment_overlap_suppression: PASSED **");
		else
			$display("** alignment_overlap_suppression: FAILED **");
		$finish;
	end

	initial begin
		#20000000;
		$display("** alignment_overlap_suppression: FAILED **");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/aos_pkg.sv
rtl/aos_cell.sv
rtl/aos_ctrl.sv
rtl/alignment_overlap_suppression.sv
dv/tb_alignment_overlap_suppression.sv
